// File: design/pl_pkg.sv
// Package for the positional list engine: widths, types, command codes
// and sequencer state codes. No dependencies; the top level and the checker use it.
`default_nettype none

package pl_pkg;

   // List storage size and the widths that follow from it.
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 16;
   localparam int WORD_W   = 32;
   localparam int KIND_W   = 4;
   localparam int CMP_W    = (POS_W > LEN_W) ? POS_W : LEN_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [KIND_W-1:0] kind_type;

   // Command codes carried on req_kind.
   localparam kind_type KIND_APPEND  = 4'd0;
   localparam kind_type KIND_INSERT  = 4'd1;
   localparam kind_type KIND_POP     = 4'd2;
   localparam kind_type KIND_CLEAR   = 4'd3;
   localparam kind_type KIND_COUNT   = 4'd4;
   localparam kind_type KIND_REVERSE = 4'd5;
   localparam kind_type KIND_LEN     = 4'd6;
   localparam kind_type KIND_SET     = 4'd7;
   localparam kind_type KIND_GET     = 4'd8;
   localparam kind_type KIND_ERASE   = 4'd9;

   // Answer to a get at a position past the end of the list.
   localparam word_type MISSING_VALUE = '1;

   // Sequencer state codes.
   typedef logic [3:0] state_type;
   localparam state_type ST_IDLE     = 4'd0;
   localparam state_type ST_COPY     = 4'd1;
   localparam state_type ST_FINAL    = 4'd2;
   localparam state_type ST_SCAN     = 4'd3;
   localparam state_type ST_GET_WAIT = 4'd4;
   localparam state_type ST_REV_LD   = 4'd5;
   localparam state_type ST_REV_A    = 4'd6;
   localparam state_type ST_REV_B    = 4'd7;
   localparam state_type ST_REV_C    = 4'd8;

endpackage

`default_nettype wire

// File: design/pl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
`default_nettype none

module pl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write when enabled; the read returns the contents before this edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: design/positional_list_engine_top.sv
// Top level of the positional list engine: command decode, sequencer and
// the element memory. Depends on pl_pkg and pl_ram.
//
// The block holds an ordered list of up to pl_pkg::CAPACITY signed 32-bit
// values in a single-port-write, single-port-read memory. A transaction is
// taken when start is high and busy is low. Append, set, pop, clear and len
// finish in the cycle they are taken, so busy stays low and the next
// transaction may follow at once; get keeps busy high through ST_GET_WAIT
// when the position exists. Count walks the list at one element a cycle;
// insert and erase move each element at or above (insert) or above (erase)
// the position by one place at one element a cycle; reverse swaps one pair
// at a time through ST_REV_A, ST_REV_B and ST_REV_C. The memory takes one
// read and one write a cycle, which sets the pace of these walks. Results
// appear on rsp_result_value for exactly one cycle, marked by rsp_strobe,
// and must be taken then: the receiver cannot stall the block. The memory
// needs no clearing pass after reset, as only entries below the current
// length are ever read.
`default_nettype none

module positional_list_engine_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [3:0]           req_kind,
   input  wire logic [15:0]          req_position,
   input  wire logic signed [31:0]   req_value,
   output logic                      rsp_strobe,
   output logic signed [31:0]        rsp_result_value
);

   pl_pkg::state_type state_ff, state_in;
   pl_pkg::len_type   len_ff, len_in;
   pl_pkg::len_type   src_ff, src_in;
   pl_pkg::len_type   hi_ff, hi_in;
   pl_pkg::len_type   cnt_ff, cnt_in;
   pl_pkg::len_type   wad_ff, wad_in;
   pl_pkg::len_type   acc_ff, acc_in;
   logic              dv_ff, dv_in;
   logic              ins_ff, ins_in;
   pl_pkg::addr_type  pos_ff, pos_in;
   pl_pkg::word_type  val_ff, val_in;
   pl_pkg::word_type  tmp_ff, tmp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   pl_pkg::word_type  rsp_value_ff, rsp_value_in;

   logic              mem_we;
   pl_pkg::addr_type  mem_waddr;
   pl_pkg::word_type  mem_wdata;
   pl_pkg::addr_type  mem_raddr;
   pl_pkg::word_type  mem_rdata;

   logic              accept;
   logic              pos_present;
   logic              pos_insertable;
   logic              list_full;
   pl_pkg::cmp_type   pos_ext;
   pl_pkg::cmp_type   len_ext;

   // Element store.
   pl_ram #(
      .WIDTH (pl_pkg::WORD_W),
      .DEPTH (pl_pkg::CAPACITY)
   ) u_pl_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Handshake and position checks against the current length.
   assign busy           = (state_ff != pl_pkg::ST_IDLE);
   assign accept         = start && !busy;
   assign pos_ext        = pl_pkg::cmp_type'(req_position);
   assign len_ext        = pl_pkg::cmp_type'(len_ff);
   assign pos_present    = (pos_ext < len_ext);
   assign pos_insertable = (pos_ext <= len_ext);
   assign list_full      = (len_ff == pl_pkg::len_type'(pl_pkg::CAPACITY));

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;

   // Sequencer: decodes a transaction and steps through memory walks.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      src_in        = src_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      wad_in        = wad_ff;
      acc_in        = acc_ff;
      dv_in         = 1'b0;
      ins_in        = ins_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      tmp_in        = tmp_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_waddr     = src_ff[pl_pkg::ADDR_W-1:0];
      mem_wdata     = mem_rdata;
      mem_raddr     = src_ff[pl_pkg::ADDR_W-1:0];

      unique case (state_ff)
         pl_pkg::ST_IDLE: begin
            if (accept) begin
               pos_in = req_position[pl_pkg::ADDR_W-1:0];
               val_in = req_value;
               unique case (req_kind)
                  pl_pkg::KIND_APPEND: begin
                     if (!list_full) begin
                        mem_we    = 1'b1;
                        mem_waddr = len_ff[pl_pkg::ADDR_W-1:0];
                        mem_wdata = req_value;
                        len_in    = len_ff + 1'b1;
                     end
                  end
                  pl_pkg::KIND_INSERT: begin
                     if (!list_full && pos_insertable) begin
                        // Move elements down from the top, one place up.
                        ins_in   = 1'b1;
                        src_in   = len_ff - 1'b1;
                        cnt_in   = pl_pkg::len_type'(len_ext - pos_ext);
                        state_in = pl_pkg::ST_COPY;
                     end
                  end
                  pl_pkg::KIND_POP: begin
                     if (len_ff != '0) begin
                        len_in = len_ff - 1'b1;
                     end
                  end
                  pl_pkg::KIND_CLEAR: begin
                     len_in = '0;
                  end
                  pl_pkg::KIND_COUNT: begin
                     src_in   = '0;
                     cnt_in   = len_ff;
                     acc_in   = '0;
                     state_in = pl_pkg::ST_SCAN;
                  end
                  pl_pkg::KIND_REVERSE: begin
                     if (len_ff > pl_pkg::len_type'(1)) begin
                        src_in   = '0;
                        hi_in    = len_ff - 1'b1;
                        state_in = pl_pkg::ST_REV_LD;
                     end
                  end
                  pl_pkg::KIND_LEN: begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = pl_pkg::word_type'(len_ff);
                  end
                  pl_pkg::KIND_SET: begin
                     if (pos_present) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_position[pl_pkg::ADDR_W-1:0];
                        mem_wdata = req_value;
                     end
                  end
                  pl_pkg::KIND_GET: begin
                     if (pos_present) begin
                        mem_raddr = req_position[pl_pkg::ADDR_W-1:0];
                        state_in  = pl_pkg::ST_GET_WAIT;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_value_in  = pl_pkg::MISSING_VALUE;
                     end
                  end
                  pl_pkg::KIND_ERASE: begin
                     if (pos_present) begin
                        // Move elements above the position one place down.
                        ins_in   = 1'b0;
                        src_in   = pl_pkg::len_type'(pos_ext + 1'b1);
                        cnt_in   = pl_pkg::len_type'(len_ext - pos_ext - 1'b1);
                        state_in = pl_pkg::ST_COPY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         pl_pkg::ST_COPY: begin
            // Write back the element read in the previous cycle.
            if (dv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wad_ff[pl_pkg::ADDR_W-1:0];
               mem_wdata = mem_rdata;
            end
            if (cnt_ff != '0) begin
               mem_raddr = src_ff[pl_pkg::ADDR_W-1:0];
               dv_in     = 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               if (ins_ff) begin
                  wad_in = src_ff + 1'b1;
                  src_in = src_ff - 1'b1;
               end else begin
                  wad_in = src_ff - 1'b1;
                  src_in = src_ff + 1'b1;
               end
            end else begin
               state_in = pl_pkg::ST_FINAL;
            end
         end

         pl_pkg::ST_FINAL: begin
            // Insert places its value in the freed slot; erase shortens.
            if (ins_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = val_ff;
               len_in    = len_ff + 1'b1;
            end else begin
               len_in    = len_ff - 1'b1;
            end
            state_in = pl_pkg::ST_IDLE;
         end

         pl_pkg::ST_SCAN: begin
            // Compare each returned element with the wanted value.
            if (dv_ff && (mem_rdata == val_ff)) begin
               acc_in = acc_ff + 1'b1;
            end
            if (cnt_ff != '0) begin
               mem_raddr = src_ff[pl_pkg::ADDR_W-1:0];
               dv_in     = 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               src_in    = src_ff + 1'b1;
            end else if (!dv_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = pl_pkg::word_type'(acc_ff);
               state_in      = pl_pkg::ST_IDLE;
            end
         end

         pl_pkg::ST_GET_WAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = mem_rdata;
            state_in      = pl_pkg::ST_IDLE;
         end

         pl_pkg::ST_REV_LD: begin
            mem_raddr = src_ff[pl_pkg::ADDR_W-1:0];
            state_in  = pl_pkg::ST_REV_A;
         end

         pl_pkg::ST_REV_A: begin
            // Low element arrives; fetch the high one.
            tmp_in    = mem_rdata;
            mem_raddr = hi_ff[pl_pkg::ADDR_W-1:0];
            state_in  = pl_pkg::ST_REV_B;
         end

         pl_pkg::ST_REV_B: begin
            mem_raddr = hi_ff[pl_pkg::ADDR_W-1:0];
            mem_we    = 1'b1;
            mem_waddr = src_ff[pl_pkg::ADDR_W-1:0];
            mem_wdata = mem_rdata;
            state_in  = pl_pkg::ST_REV_C;
         end

         pl_pkg::ST_REV_C: begin
            // Finish the swap and start on the next pair if any is left.
            mem_we    = 1'b1;
            mem_waddr = hi_ff[pl_pkg::ADDR_W-1:0];
            mem_wdata = tmp_ff;
            src_in    = src_ff + 1'b1;
            hi_in     = hi_ff - 1'b1;
            mem_raddr = src_in[pl_pkg::ADDR_W-1:0];
            if ((src_ff + pl_pkg::len_type'(2)) < hi_ff) begin
               state_in = pl_pkg::ST_REV_A;
            end else begin
               state_in = pl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pl_pkg::ST_IDLE;
         len_ff        <= '0;
         dv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         dv_ff         <= dv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      hi_ff        <= hi_in;
      cnt_ff       <= cnt_in;
      wad_ff       <= wad_in;
      acc_ff       <= acc_in;
      ins_ff       <= ins_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      tmp_ff       <= tmp_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire

// File: design/pl_checker.sv
// Port-level checks for the positional list engine and the bind that
// attaches them to the top level. Depends on pl_pkg.
`default_nettype none

module pl_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic [3:0]           req_kind,
   input wire logic [15:0]          req_position,
   input wire logic signed [31:0]   req_value,
   input wire logic                 rsp_strobe,
   input wire logic signed [31:0]   rsp_result_value
);

   logic accept;
   assign accept = start && !busy;

   // A result only follows a taken transaction or work in progress.
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(accept) || $past(busy)))
      else $error("result without a transaction behind it");

   // Len answers in the next cycle and leaves the block free.
   a_len_immediate: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == pl_pkg::KIND_LEN) |=> (rsp_strobe && !busy))
      else $error("len did not answer in the next cycle");

   // Commands that finish at once leave no work and no result behind.
   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == pl_pkg::KIND_APPEND || req_kind == pl_pkg::KIND_POP ||
                  req_kind == pl_pkg::KIND_CLEAR || req_kind == pl_pkg::KIND_SET ||
                  req_kind > pl_pkg::KIND_ERASE))
      |=> (!busy && !rsp_strobe))
      else $error("single-cycle command left the block busy or answered");

   // Get either answers at once or keeps the block busy for its read.
   a_get_progress: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == pl_pkg::KIND_GET) |=> (rsp_strobe || busy))
      else $error("get neither answered nor started its read");

   // After a clear the length reads back as zero.
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == pl_pkg::KIND_CLEAR) ##1
      (accept && req_kind == pl_pkg::KIND_LEN)
      |=> (rsp_strobe && rsp_result_value == 32'sd0))
      else $error("length not zero after clear");

endmodule

bind positional_list_engine_top pl_checker u_pl_checker (.*);

`default_nettype wire
